### sv/fccm_pkg.sv
// Shared widths, codes and controller/datapath command types for the FAT chain manager.
`default_nettype none

package fccm_pkg;

    localparam int IDX_W   = 10;
    localparam int ENT_W   = 11;
    localparam int CMD_W   = 3;
    localparam int STAT_W  = 2;
    localparam int PADDR_W = 2;
    localparam int PDATA_W = 32;

    localparam logic [ENT_W-1:0] END_MARK  = 11'h7FF;
    localparam logic [IDX_W-1:0] FSC_RESET = 10'd4;

    localparam logic [PADDR_W-1:0] ADDR_FSC = 2'd0;

    localparam logic [CMD_W-1:0] CMD_NEW    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_EXTEND = 3'd1;
    localparam logic [CMD_W-1:0] CMD_FIND   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_WRITE  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOFREE = 2'd1;
    localparam logic [STAT_W-1:0] ST_LONG   = 2'd2;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_CLEAR,
        OP_SCAN,
        OP_NEW_MARK,
        OP_NEW_FAIL,
        OP_LINK,
        OP_EXT_MARK,
        OP_EXT_DONE,
        OP_EXT_OOB,
        OP_WALK_INIT,
        OP_WALK_STEP,
        OP_WALK_FIN,
        OP_WALK_OOB,
        OP_WR,
        OP_RD_ISSUE,
        OP_RD_FIN,
        OP_ZERO
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic hit;
        logic exhausted;
        logic cl_oob;
        logic cnt_done;
        logic walk_stop;
    } t_dp_stat;

endpackage

`default_nettype wire

### sv/fccm_if.sv
// Request and response channel interfaces of the FAT chain manager.
`default_nettype none

interface fccm_req_if;
    import fccm_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [IDX_W-1:0]  cluster;
    logic [IDX_W-1:0]  count;
    logic [ENT_W-1:0]  entry_value;

    modport source (output valid, output cmd, output cluster, output count,
                    output entry_value, input ready);
    modport sink   (input valid, input cmd, input cluster, input count,
                    input entry_value, output ready);
endinterface

interface fccm_rsp_if;
    import fccm_pkg::*;

    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [IDX_W-1:0]  result_cluster;
    logic [IDX_W-1:0]  allocated;
    logic [ENT_W-1:0]  read_value;

    modport source (output valid, output status, output result_cluster,
                    output allocated, output read_value, input ready);
    modport sink   (input valid, input status, input result_cluster,
                    input allocated, input read_value, output ready);
endinterface

`default_nettype wire

### sv/fccm_datapath.sv
// Table memory, scan/walk registers and result registers of the FAT chain manager.
`default_nettype none

module fccm_datapath import fccm_pkg::*; #(
    parameter int NUM_CLUSTERS = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_stat          o_stat,
    input  logic [IDX_W-1:0]  i_first_search,
    input  logic [IDX_W-1:0]  i_cluster,
    input  logic [IDX_W-1:0]  i_count,
    input  logic [ENT_W-1:0]  i_entry_value,
    output logic [STAT_W-1:0] o_status,
    output logic [IDX_W-1:0]  o_result_cluster,
    output logic [IDX_W-1:0]  o_allocated,
    output logic [ENT_W-1:0]  o_read_value
);

    localparam int CW = $clog2(NUM_CLUSTERS);
    localparam logic [CW:0]      SCAN_N   = (CW+1)'(NUM_CLUSTERS);
    localparam logic [ENT_W-1:0] ENT_N    = ENT_W'(NUM_CLUSTERS);
    localparam logic [IDX_W:0]   IDX_N    = (IDX_W+1)'(NUM_CLUSTERS);
    localparam logic [CW-1:0]    LAST_IDX = CW'(NUM_CLUSTERS - 1);

    logic [ENT_W-1:0] r_mem [NUM_CLUSTERS];

    // control registers
    logic [CW:0]   r_scan;
    logic          r_rd_vld;

    // payload registers
    logic [CW-1:0]     r_rd_idx;
    logic [ENT_W-1:0]  r_rdata;
    logic [IDX_W-1:0]  r_cl;
    logic [IDX_W-1:0]  r_cnt;
    logic [ENT_W-1:0]  r_val;
    logic [IDX_W-1:0]  r_tail;
    logic [IDX_W-1:0]  r_alloc;
    logic [CW-1:0]     r_found;
    logic [CW-1:0]     r_steps;
    logic [STAT_W-1:0] r_res_status;
    logic [IDX_W-1:0]  r_res_cluster;
    logic [ENT_W-1:0]  r_res_read;

    logic             mem_we;
    logic [CW-1:0]    mem_wa;
    logic [ENT_W-1:0] mem_wd;
    logic             mem_re;
    logic [CW-1:0]    mem_ra;
    logic             cl_oob;
    logic             fsc_oob;

    assign cl_oob  = {1'b0, r_cl} >= IDX_N;
    assign fsc_oob = {1'b0, i_first_search} >= IDX_N;

    always_comb begin
        o_stat.clr_last  = r_scan[CW-1:0] == LAST_IDX;
        o_stat.hit       = r_rd_vld && (r_rdata == '0);
        o_stat.exhausted = !o_stat.hit && (r_scan >= SCAN_N);
        o_stat.cl_oob    = cl_oob;
        o_stat.cnt_done  = r_alloc == r_cnt;
        o_stat.walk_stop = (r_rdata >= ENT_N) || (r_steps == LAST_IDX);
    end

    // memory port selection
    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_tail[CW-1:0];
        mem_wd = '0;
        mem_re = 1'b0;
        mem_ra = r_scan[CW-1:0];
        case (i_cmd.op)
            OP_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = r_scan[CW-1:0];
            end
            OP_SCAN: begin
                mem_re = 1'b1;
            end
            OP_NEW_MARK: begin
                mem_we = 1'b1;
                mem_wa = r_rd_idx;
                mem_wd = END_MARK;
            end
            OP_LINK: begin
                mem_we = 1'b1;
                mem_wd = ENT_W'(r_rd_idx);
            end
            OP_EXT_MARK: begin
                mem_we = 1'b1;
                mem_wa = r_found;
                mem_wd = END_MARK;
            end
            OP_WALK_INIT, OP_RD_ISSUE: begin
                mem_re = 1'b1;
                mem_ra = r_cl[CW-1:0];
            end
            OP_WALK_STEP: begin
                mem_re = 1'b1;
                mem_ra = r_rdata[CW-1:0];
            end
            OP_WR: begin
                mem_we = !cl_oob;
                mem_wa = r_cl[CW-1:0];
                mem_wd = r_val;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan   <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            case (i_cmd.op)
                OP_LOAD: begin
                    r_scan   <= fsc_oob ? SCAN_N : (CW+1)'(i_first_search);
                    r_rd_vld <= 1'b0;
                end
                OP_CLEAR: begin
                    r_scan <= r_scan + 1'b1;
                end
                OP_SCAN: begin
                    r_scan   <= r_scan + 1'b1;
                    r_rd_vld <= 1'b1;
                end
                OP_EXT_MARK: begin
                    // resume the search just above the cluster taken
                    r_scan   <= (CW+1)'(r_found) + 1'b1;
                    r_rd_vld <= 1'b0;
                end
                default: begin
                    r_rd_vld <= r_rd_vld;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_cl    <= i_cluster;
                r_cnt   <= i_count;
                r_val   <= i_entry_value;
                r_tail  <= i_cluster;
                r_alloc <= '0;
                r_steps <= '0;
            end
            OP_SCAN: begin
                r_rd_idx <= r_scan[CW-1:0];
            end
            OP_NEW_MARK: begin
                r_res_status  <= ST_OK;
                r_res_cluster <= IDX_W'(r_rd_idx);
                r_res_read    <= '0;
            end
            OP_NEW_FAIL: begin
                r_res_status  <= ST_NOFREE;
                r_res_cluster <= '0;
                r_res_read    <= '0;
            end
            OP_LINK: begin
                r_found <= r_rd_idx;
            end
            OP_EXT_MARK: begin
                r_tail  <= IDX_W'(r_found);
                r_alloc <= r_alloc + 1'b1;
            end
            OP_EXT_DONE: begin
                r_res_status  <= (r_alloc == r_cnt) ? ST_OK : ST_NOFREE;
                r_res_cluster <= r_tail;
                r_res_read    <= '0;
            end
            OP_EXT_OOB: begin
                r_res_status  <= ST_NOFREE;
                r_res_cluster <= r_cl;
                r_res_read    <= '0;
            end
            OP_WALK_STEP: begin
                r_tail  <= r_rdata[IDX_W-1:0];
                r_steps <= r_steps + 1'b1;
            end
            OP_WALK_FIN: begin
                r_res_read <= '0;
                if (r_rdata == END_MARK) begin
                    r_res_status  <= ST_OK;
                    r_res_cluster <= r_tail;
                end else if (r_rdata >= ENT_N) begin
                    r_res_status  <= ST_LONG;
                    r_res_cluster <= r_tail;
                end else begin
                    // step budget spent: report where the walk would go next
                    r_res_status  <= ST_LONG;
                    r_res_cluster <= r_rdata[IDX_W-1:0];
                end
            end
            OP_WALK_OOB: begin
                r_res_status  <= ST_LONG;
                r_res_cluster <= r_cl;
                r_res_read    <= '0;
            end
            OP_RD_FIN: begin
                r_res_status  <= ST_OK;
                r_res_cluster <= '0;
                r_res_read    <= cl_oob ? '0 : r_rdata;
            end
            OP_WR, OP_ZERO: begin
                r_res_status  <= ST_OK;
                r_res_cluster <= '0;
                r_res_read    <= '0;
            end
            default: begin
                r_tail <= r_tail;
            end
        endcase

        if (i_cmd.load_out) begin
            o_status         <= r_res_status;
            o_result_cluster <= r_res_cluster;
            o_allocated      <= r_alloc;
            o_read_value     <= r_res_read;
        end
    end

    a_mark_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_EXT_MARK) |=> (r_alloc == $past(r_alloc) + 1'b1))
        else $error("extend link not counted");

    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_SCAN) |-> (r_scan < SCAN_N))
        else $error("scan read issued beyond table");

    a_walk_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_WALK_STEP) |-> (r_rdata < ENT_N))
        else $error("walk step follows a link beyond the table");

endmodule

`default_nettype wire

### sv/fccm_ctrl.sv
// Command sequencer of the FAT chain manager: clear pass, scans, walks and response hand-off.
`default_nettype none

module fccm_ctrl import fccm_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [CMD_W-1:0] i_in_cmd,
    output logic             o_in_ready,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    input  t_dp_stat         i_stat,
    output t_dp_cmd          o_cmd
);

    typedef enum logic [11:0] {
        S_CLEAR    = 12'b0000_0000_0001,
        S_IDLE     = 12'b0000_0000_0010,
        S_NEW      = 12'b0000_0000_0100,
        S_EXT      = 12'b0000_0000_1000,
        S_EXT_MARK = 12'b0000_0001_0000,
        S_WALK0    = 12'b0000_0010_0000,
        S_WALK     = 12'b0000_0100_0000,
        S_WR       = 12'b0000_1000_0000,
        S_RD       = 12'b0001_0000_0000,
        S_RD_DATA  = 12'b0010_0000_0000,
        S_ZERO     = 12'b0100_0000_0000,
        S_RESP     = 12'b1000_0000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    assign o_in_ready  = r_state == S_IDLE;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state        = r_state;
        n_out_valid    = r_out_valid && !i_out_ready;
        o_cmd.op       = OP_NONE;
        o_cmd.load_out = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.op = OP_CLEAR;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    case (i_in_cmd)
                        CMD_NEW:    n_state = S_NEW;
                        CMD_EXTEND: n_state = S_EXT;
                        CMD_FIND:   n_state = S_WALK0;
                        CMD_WRITE:  n_state = S_WR;
                        CMD_READ:   n_state = S_RD;
                        default:    n_state = S_ZERO;
                    endcase
                end
            end
            S_NEW: begin
                if (i_stat.hit) begin
                    o_cmd.op = OP_NEW_MARK;
                    n_state  = S_RESP;
                end else if (i_stat.exhausted) begin
                    o_cmd.op = OP_NEW_FAIL;
                    n_state  = S_RESP;
                end else begin
                    o_cmd.op = OP_SCAN;
                end
            end
            S_EXT: begin
                if (i_stat.cl_oob) begin
                    o_cmd.op = OP_EXT_OOB;
                    n_state  = S_RESP;
                end else if (i_stat.cnt_done) begin
                    o_cmd.op = OP_EXT_DONE;
                    n_state  = S_RESP;
                end else if (i_stat.hit) begin
                    o_cmd.op = OP_LINK;
                    n_state  = S_EXT_MARK;
                end else if (i_stat.exhausted) begin
                    o_cmd.op = OP_EXT_DONE;
                    n_state  = S_RESP;
                end else begin
                    o_cmd.op = OP_SCAN;
                end
            end
            S_EXT_MARK: begin
                o_cmd.op = OP_EXT_MARK;
                n_state  = S_EXT;
            end
            S_WALK0: begin
                if (i_stat.cl_oob) begin
                    o_cmd.op = OP_WALK_OOB;
                    n_state  = S_RESP;
                end else begin
                    o_cmd.op = OP_WALK_INIT;
                    n_state  = S_WALK;
                end
            end
            S_WALK: begin
                if (i_stat.walk_stop) begin
                    o_cmd.op = OP_WALK_FIN;
                    n_state  = S_RESP;
                end else begin
                    o_cmd.op = OP_WALK_STEP;
                end
            end
            S_WR: begin
                o_cmd.op = OP_WR;
                n_state  = S_RESP;
            end
            S_RD: begin
                o_cmd.op = OP_RD_ISSUE;
                n_state  = S_RD_DATA;
            end
            S_RD_DATA: begin
                o_cmd.op = OP_RD_FIN;
                n_state  = S_RESP;
            end
            S_ZERO: begin
                o_cmd.op = OP_ZERO;
                n_state  = S_RESP;
            end
            S_RESP: begin
                // hold until the output word slot frees up
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second word accepted while a command is in flight");

    a_resp_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESP && (!r_out_valid || i_out_ready)) |=> o_out_valid)
        else $error("finished result not presented");

    a_resp_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESP && r_out_valid && !i_out_ready) |=> (r_state == S_RESP))
        else $error("result dropped while output stalled");

endmodule

`default_nettype wire

### sv/fat_cluster_chain_manager_core.sv
// FAT cluster chain manager: a table of NUM_CLUSTERS 11-bit entries with chain commands.
// Usage:
//   Request words (cmd, cluster, count, entry_value) arrive on i_req; one response word
//   (status, result_cluster, allocated, read_value) leaves on o_rsp for every request.
//   Both channels move a word when valid and ready are high at a rising clock edge.
//   The APB port holds first_search_cluster at address 0; write it only while idle.
// Commands, one at a time:
//   new chain      : scans entries upward from first_search_cluster for a free one
//   extend         : scans the same way and links each free cluster found (scan resumes after each)
//   find last      : walks the chain, at most NUM_CLUSTERS - 1 steps
//   The free search and the chain walk read one table entry per cycle (extend pauses to
//   link each cluster found) from the single read port of the table memory.
// Reset: synchronous, active low. A clearing pass then zeroes the table, one entry per
//   cycle; i_req.ready stays low until it completes.
// Stall: a finished response sits in the output register; the next request is accepted
//   meanwhile, and its own response waits until the output register frees up.
`default_nettype none

module fat_cluster_chain_manager_core import fccm_pkg::*; #(
    parameter int NUM_CLUSTERS = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    fccm_req_if.sink            i_req,
    fccm_rsp_if.source          o_rsp,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready
);

    logic [IDX_W-1:0] r_first_search;
    t_dp_cmd          dp_cmd;
    t_dp_stat         dp_stat;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_FSC) ? PDATA_W'(r_first_search) : '0;

    // single register: every write lands on it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_search <= FSC_RESET;
        end else if (psel && penable && pwrite && pready) begin
            r_first_search <= pwdata[IDX_W-1:0];
        end
    end

    fccm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_in_cmd    (i_req.cmd),
        .o_in_ready  (i_req.ready),
        .i_out_ready (o_rsp.ready),
        .o_out_valid (o_rsp.valid),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    fccm_datapath #(
        .NUM_CLUSTERS (NUM_CLUSTERS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (dp_cmd),
        .o_stat           (dp_stat),
        .i_first_search   (r_first_search),
        .i_cluster        (i_req.cluster),
        .i_count          (i_req.count),
        .i_entry_value    (i_req.entry_value),
        .o_status         (o_rsp.status),
        .o_result_cluster (o_rsp.result_cluster),
        .o_allocated      (o_rsp.allocated),
        .o_read_value     (o_rsp.read_value)
    );

endmodule

`default_nettype wire

### tb/fccm_chain_checker.sv
// Allocation-table predictor and response comparator for the FAT chain manager bench.
module fccm_chain_checker import fccm_pkg::*; #(
    parameter int NUM_CLUSTERS = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    fccm_req_if                i_req,
    fccm_rsp_if                i_rsp,
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic               i_pready,
    input  logic [PADDR_W-1:0] i_paddr,
    input  logic [PDATA_W-1:0] i_pwdata,
    output int                 o_fail_count,
    output int                 o_pending
);

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [IDX_W-1:0]  result_cluster;
        logic [IDX_W-1:0]  allocated;
        logic [ENT_W-1:0]  read_value;
    } t_chain_reply;

    logic [ENT_W-1:0] alloc_table [NUM_CLUSTERS];
    int               search_base;
    int               fails;
    t_chain_reply     pending_replies [$];

    // Lowest free entry at or above the search base.
    function automatic bit find_free_cluster(output int found);
        for (int i = search_base; i < NUM_CLUSTERS; i++) begin
            if (alloc_table[i] == '0) begin
                found = i;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic t_chain_reply run_table_command(input logic [CMD_W-1:0] op,
                                                       input logic [IDX_W-1:0] cl,
                                                       input logic [IDX_W-1:0] cnt,
                                                       input logic [ENT_W-1:0] val);
        t_chain_reply     reply;
        int               free_cl;
        int               tail;
        int               cur;
        int               linked;
        bit               reached_end;
        logic [ENT_W-1:0] link;
        reply = '0;
        linked = 0;
        case (op)
            CMD_NEW: begin
                if (find_free_cluster(free_cl)) begin
                    alloc_table[free_cl] = END_MARK;
                    reply.result_cluster = IDX_W'(free_cl);
                end else begin
                    reply.status = ST_NOFREE;
                end
            end
            CMD_EXTEND: begin
                tail = int'(cl);
                if (tail >= NUM_CLUSTERS) begin
                    reply.status = ST_NOFREE;
                end else begin
                    // a free tail may be picked by the search; the end mark then wins
                    while (linked < int'(cnt)) begin
                        if (!find_free_cluster(free_cl)) break;
                        alloc_table[tail]    = ENT_W'(free_cl);
                        alloc_table[free_cl] = END_MARK;
                        tail = free_cl;
                        linked++;
                    end
                    if (linked < int'(cnt)) reply.status = ST_NOFREE;
                end
                reply.result_cluster = IDX_W'(tail);
                reply.allocated      = IDX_W'(linked);
            end
            CMD_FIND: begin
                cur = int'(cl);
                if (cur >= NUM_CLUSTERS) begin
                    reply.status = ST_LONG;
                end else begin
                    reached_end = 1'b0;
                    for (int steps = 0; steps < NUM_CLUSTERS; steps++) begin
                        link = alloc_table[cur];
                        if (link == END_MARK) begin
                            reached_end = 1'b1;
                            break;
                        end
                        if (int'(link) >= NUM_CLUSTERS) break;
                        cur = int'(link);
                    end
                    if (!reached_end) reply.status = ST_LONG;
                end
                reply.result_cluster = IDX_W'(cur);
            end
            CMD_WRITE: begin
                if (int'(cl) < NUM_CLUSTERS) alloc_table[cl] = val;
            end
            CMD_READ: begin
                if (int'(cl) < NUM_CLUSTERS) reply.read_value = alloc_table[cl];
            end
            default: ;
        endcase
        return reply;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fails++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_chain_reply want;
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CLUSTERS; i++) alloc_table[i] = '0;
            search_base = int'(FSC_RESET);
            pending_replies.delete();
            fails = 0;
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                if (pending_replies.size() == 0) begin
                    $error("response word with no command outstanding");
                    fails++;
                end else begin
                    want = pending_replies.pop_front();
                    check_field("status", int'(want.status), int'(i_rsp.status));
                    check_field("result_cluster", int'(want.result_cluster),
                                int'(i_rsp.result_cluster));
                    check_field("allocated", int'(want.allocated), int'(i_rsp.allocated));
                    check_field("read_value", int'(want.read_value), int'(i_rsp.read_value));
                end
            end
            if (i_req.valid && i_req.ready) begin
                pending_replies.push_back(run_table_command(i_req.cmd, i_req.cluster,
                                                            i_req.count, i_req.entry_value));
            end
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == ADDR_FSC) begin
                search_base = int'(i_pwdata[IDX_W-1:0]);
            end
        end
        o_pending    = pending_replies.size();
        o_fail_count = fails;
    end

endmodule

### tb/tb_top.sv
// Stimulus, idling control and verdict for the FAT cluster chain manager bench.
module tb_top;
    import fccm_pkg::*;

    localparam int NUM_CLUSTERS    = 1024;
    localparam int RAND_PHASES     = 8;
    localparam int WORDS_PER_PHASE = 70;
    localparam int PRESSURE_PHASE  = 6;
    localparam int HOLD_CYCLES     = 400;
    localparam int REGION_SPAN     = 95;

    localparam logic [CMD_W-1:0] CMD_UNKNOWN_LO = 3'd5;
    localparam logic [CMD_W-1:0] CMD_UNKNOWN_HI = 3'd7;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    int fail_count;
    int pending;
    int idle_pct    = 0;
    int stall_pct   = 0;
    int search_base = int'(FSC_RESET);
    bit hold_rsp;
    bit pressure_on = 1'b0;

    fccm_req_if req_ch ();
    fccm_rsp_if rsp_ch ();

    fat_cluster_chain_manager_core #(
        .NUM_CLUSTERS(NUM_CLUSTERS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch),
        .o_rsp  (rsp_ch),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready)
    );

    fccm_chain_checker #(
        .NUM_CLUSTERS(NUM_CLUSTERS)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_ch),
        .i_rsp       (rsp_ch),
        .i_psel      (psel),
        .i_penable   (penable),
        .i_pwrite    (pwrite),
        .i_pready    (pready),
        .i_paddr     (paddr),
        .i_pwdata    (pwdata),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        rsp_ch.ready <= !hold_rsp && ($urandom_range(99) >= stall_pct);
    end

    // Hold off the receiver so the output register and the core back up.
    initial begin
        hold_rsp = 1'b0;
        wait (pressure_on);
        @(posedge i_clk);
        hold_rsp <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_rsp <= 1'b0;
    end

    initial begin
        #40000000;
        $display("Verification failed");
        $finish;
    end

    // Leaves valid high after acceptance; the next call or settle() decides.
    task automatic send_word(input logic [CMD_W-1:0] op, input logic [IDX_W-1:0] cl,
                             input logic [IDX_W-1:0] cnt, input logic [ENT_W-1:0] val);
        while ($urandom_range(99) < idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.cmd         <= op;
        req_ch.cluster     <= cl;
        req_ch.count       <= cnt;
        req_ch.entry_value <= val;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
    endtask

    task automatic settle();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_search_base(input int value);
        search_base = value;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_FSC;
        pwdata  <= PDATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Mostly commands aimed at the region where the search allocates, so chains form.
    task automatic send_random_word();
        int               pick;
        int               sel;
        int               top_cl;
        logic [CMD_W-1:0] op;
        logic [IDX_W-1:0] cl;
        logic [IDX_W-1:0] cnt;
        logic [ENT_W-1:0] val;
        pick   = $urandom_range(99);
        sel    = $urandom_range(99);
        top_cl = (search_base + REGION_SPAN > NUM_CLUSTERS - 1) ? NUM_CLUSTERS - 1
                                                                : search_base + REGION_SPAN;
        cl  = ($urandom_range(9) < 7) ? IDX_W'($urandom_range(top_cl, search_base))
                                      : IDX_W'($urandom);
        cnt = IDX_W'($urandom);
        val = ENT_W'($urandom);
        if (pick < 18) begin
            op = CMD_NEW;
        end else if (pick < 40) begin
            op = CMD_EXTEND;
            if (sel < 80) cnt = IDX_W'($urandom_range(6));
            else if (sel < 95) cnt = IDX_W'($urandom_range(40));
        end else if (pick < 60) begin
            op = CMD_FIND;
        end else if (pick < 80) begin
            op = CMD_WRITE;
            if (sel < 40) val = '0;
            else if (sel < 65) val = ENT_W'($urandom_range(top_cl, search_base));
            else if (sel < 80) val = END_MARK;
        end else if (pick < 95) begin
            op = CMD_READ;
        end else begin
            op = CMD_W'($urandom_range(CMD_UNKNOWN_HI, CMD_UNKNOWN_LO));
        end
        send_word(op, cl, cnt, val);
    endtask

    initial begin
        req_ch.valid       = 1'b0;
        req_ch.cmd         = CMD_NEW;
        req_ch.cluster     = '0;
        req_ch.count       = '0;
        req_ch.entry_value = '0;
        rsp_ch.ready       = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = ADDR_FSC;
        pwdata             = '0;
        i_rst_n            = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // fresh table, search from the reset base
        send_word(CMD_READ, 0, 0, 0);
        send_word(CMD_NEW, 0, 0, 0);
        send_word(CMD_EXTEND, 4, 3, 0);
        send_word(CMD_EXTEND, 7, 0, 0);
        send_word(CMD_FIND, 4, 0, 0);
        send_word(CMD_WRITE, 1023, 0, END_MARK);
        send_word(CMD_READ, 1023, 0, 0);
        // a free entry in a chain leads to cluster 0, which loops on itself
        send_word(CMD_WRITE, 20, 0, 21);
        send_word(CMD_WRITE, 21, 0, 0);
        send_word(CMD_FIND, 20, 0, 0);
        // link past the table
        send_word(CMD_WRITE, 30, 0, 2046);
        send_word(CMD_FIND, 30, 0, 0);
        send_word(CMD_UNKNOWN_LO, 5, 9, 100);
        send_word(CMD_UNKNOWN_HI, 1023, 1023, END_MARK);
        settle();

        // only the top entry is searchable
        write_search_base(1023);
        send_word(CMD_NEW, 0, 0, 0);
        send_word(CMD_WRITE, 1023, 0, 0);
        send_word(CMD_EXTEND, 1023, 1023, 0);
        send_word(CMD_EXTEND, 5, 2, 0);
        send_word(CMD_NEW, 1023, 1023, END_MARK);
        settle();

        write_search_base(1);
        send_word(CMD_NEW, 0, 0, 0);
        send_word(CMD_WRITE, 0, 0, 0);
        send_word(CMD_READ, 0, 0, 0);
        send_word(CMD_FIND, 1, 0, 0);

        for (int p = 0; p < RAND_PHASES; p++) begin
            settle();
            write_search_base((p == 0) ? 1 : (p == 2) ? 1023 : $urandom_range(1023, 1));
            case (p % 4)
                0: begin
                    idle_pct  <= 0;
                    stall_pct <= 0;
                end
                1: begin
                    idle_pct  <= 65;
                    stall_pct <= 0;
                end
                2: begin
                    idle_pct  <= 0;
                    stall_pct <= 65;
                end
                default: begin
                    idle_pct  <= 34;
                    stall_pct <= 34;
                end
            endcase
            if (p == PRESSURE_PHASE) pressure_on <= 1'b1;
            repeat (WORDS_PER_PHASE) send_random_word();
        end
        settle();

        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

### sim.f
sv/fccm_pkg.sv
sv/fccm_if.sv
sv/fccm_datapath.sv
sv/fccm_ctrl.sv
sv/fat_cluster_chain_manager_core.sv
tb/fccm_chain_checker.sv
tb/tb_top.sv
